FILE: rtl/core/awr_pkg.sv
// ----------------------------------------------------------------------------
// awr_pkg
// Shared types and constants for the accelerometer window rank and heading
// core.
// ----------------------------------------------------------------------------
package awr_pkg;

  localparam int WINDOW_DEPTH = 32;

  localparam int AXIS_W   = 10;
  localparam int AXES     = 3;
  localparam int SAMPLE_W = AXES * AXIS_W;
  localparam int HEAD_W   = 3;
  localparam int RANK_W   = 7;
  localparam int SPREAD_W = 10;
  localparam int THR_W    = 10;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  localparam int CNT_W = $clog2(WINDOW_DEPTH);
  localparam int REM_W = $clog2(WINDOW_DEPTH);

  // Each window entry at or below the new value adds 100/N to the rank.
  localparam int RANK_STEP_Q = 100 / WINDOW_DEPTH;
  localparam int RANK_STEP_R = 100 % WINDOW_DEPTH;

  localparam logic [RANK_W-1:0] RANK_Q1 = RANK_W'(25);
  localparam logic [RANK_W-1:0] RANK_Q2 = RANK_W'(50);
  localparam logic [RANK_W-1:0] RANK_Q3 = RANK_W'(75);

  localparam logic [HEAD_W-1:0] HEAD_DOWN_FAST = 3'b110;
  localparam logic [HEAD_W-1:0] HEAD_DOWN_SLOW = 3'b111;
  localparam logic [HEAD_W-1:0] HEAD_HOLD      = 3'b000;
  localparam logic [HEAD_W-1:0] HEAD_UP_SLOW   = 3'b001;
  localparam logic [HEAD_W-1:0] HEAD_UP_FAST   = 3'b010;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } awr_state_e;

  typedef struct packed {
    logic step;
    logic first;
  } awr_scan_ctrl_t;

endpackage

FILE: rtl/core/awr_cell.sv
// ----------------------------------------------------------------------------
// awr_cell
// One window cell: holds a three-axis sample and takes its neighbor's word
// whenever the row shifts.
// ----------------------------------------------------------------------------
module awr_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  awr_pkg::sample_t prev_i,
  output awr_pkg::sample_t data_o
);
  import awr_pkg::*;

  sample_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= prev_i;
    end
  end

  assign data_o = data_q;

endmodule

FILE: rtl/core/awr_axis.sv
// ----------------------------------------------------------------------------
// awr_axis
// Per-axis scan unit: folds the window entries passing the row's tail into a
// minimum, a maximum and a running percentile rank, and derives the heading.
// ----------------------------------------------------------------------------
module awr_axis (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  awr_pkg::awr_scan_ctrl_t             ctrl_i,
  input  logic signed [awr_pkg::AXIS_W-1:0]   now_i,
  input  logic signed [awr_pkg::AXIS_W-1:0]   entry_i,
  input  logic        [awr_pkg::THR_W-1:0]    thr_i,
  output logic        [awr_pkg::HEAD_W-1:0]   heading_o,
  output logic        [awr_pkg::RANK_W-1:0]   rank_o,
  output logic        [awr_pkg::SPREAD_W-1:0] spread_o
);
  import awr_pkg::*;

  logic signed [AXIS_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic        [RANK_W-1:0] quo_q, quo_d, quo_base;
  logic        [REM_W-1:0]  rem_q, rem_d, rem_base;
  logic        [REM_W:0]    rem_sum;
  logic        [AXIS_W:0]   diff;

  always_comb begin
    quo_base = ctrl_i.first ? '0 : quo_q;
    rem_base = ctrl_i.first ? '0 : rem_q;
    rem_sum  = {1'b0, rem_base} + (REM_W + 1)'(RANK_STEP_R);
    quo_d    = quo_base;
    rem_d    = rem_base;
    if (now_i >= entry_i) begin
      if (rem_sum >= (REM_W + 1)'(WINDOW_DEPTH)) begin
        rem_d = REM_W'(rem_sum - (REM_W + 1)'(WINDOW_DEPTH));
        quo_d = quo_base + RANK_W'(RANK_STEP_Q + 1);
      end else begin
        rem_d = rem_sum[REM_W-1:0];
        quo_d = quo_base + RANK_W'(RANK_STEP_Q);
      end
    end
    lo_d = (ctrl_i.first || entry_i < lo_q) ? entry_i : lo_q;
    hi_d = (ctrl_i.first || entry_i > hi_q) ? entry_i : hi_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      hi_q  <= '0;
      quo_q <= '0;
      rem_q <= '0;
    end else if (ctrl_i.step) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    diff     = {hi_q[AXIS_W-1], hi_q} - {lo_q[AXIS_W-1], lo_q};
    spread_o = diff[SPREAD_W-1:0];
    rank_o   = quo_q;
    priority if (spread_o <= thr_i) begin
      heading_o = HEAD_HOLD;
    end else if (quo_q <= RANK_Q1) begin
      heading_o = HEAD_DOWN_FAST;
    end else if (quo_q <= RANK_Q2) begin
      heading_o = HEAD_DOWN_SLOW;
    end else if (quo_q <= RANK_Q3) begin
      heading_o = HEAD_UP_SLOW;
    end else begin
      heading_o = HEAD_UP_FAST;
    end
  end

endmodule

FILE: rtl/core/accel_window_rank_heading_core.sv
// ----------------------------------------------------------------------------
// accel_window_rank_heading_core
// Percentile rank, window spread and heading for a three-axis accelerometer.
// ----------------------------------------------------------------------------
// The slave stream takes one sample word per item: x in bits 9:0, y in 19:10
// and z in 29:20, each signed. The master stream returns one result word per
// sample with the heading, rank and spread of each axis.
// The window is a row of WINDOW_DEPTH cells. After a word is taken the row
// rotates once around, one cell per cycle, past three scan units; then the
// new sample shifts into the head and the oldest entry drops off the tail.
// A result word is written to the output register once the row has rotated
// around, and no new sample is taken while an item is still in the row.
// A new sample is taken in the cycle after the result is written to the
// output register, even while that result still waits to be taken; a stalled
// receiver holds the block in its final step until the register frees.
// The threshold port is always ready; write it only while the core is idle.
// Reset clears every window entry, the threshold and both streams at once.
// ----------------------------------------------------------------------------
module accel_window_rank_heading_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: sample_x, sample_y, sample_z, unused pad.
  input  logic [awr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: heading_x, heading_y, heading_z, rank_x, rank_y,
  // rank_z, spread_x, spread_y, spread_z, zero pad.
  output logic [awr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [awr_pkg::THR_W-1:0]       cfg_data_i
);
  import awr_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_DEPTH - 1);

  awr_state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  sample_t        sample_q;
  logic [THR_W-1:0] thr_q;
  logic           out_free;
  logic           accept;
  logic           ring_shift;
  logic           ring_load;
  logic           out_load;
  awr_scan_ctrl_t scan_ctrl;
  sample_t        head_in;
  sample_t        cell_data [WINDOW_DEPTH];
  sample_t        tail;

  logic [HEAD_W-1:0]   heading [AXES];
  logic [RANK_W-1:0]   rank    [AXES];
  logic [SPREAD_W-1:0] spread  [AXES];

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [OUT_DATA_W-1:0] result;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tail          = cell_data[WINDOW_DEPTH-1];
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready   = 1'b0;
    ring_shift      = 1'b0;
    ring_load       = 1'b0;
    out_load        = 1'b0;
    scan_ctrl.step  = 1'b0;
    scan_ctrl.first = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_SCAN: begin
        ring_shift      = 1'b1;
        scan_ctrl.step  = 1'b1;
        scan_ctrl.first = (cnt_q == '0);
      end
      ST_DONE: begin
        ring_shift = out_free;
        ring_load  = out_free;
        out_load   = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      thr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= s_axis_tdata[SAMPLE_W-1:0];
    end
  end

  assign head_in = ring_load ? sample_q : tail;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      awr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring_shift),
        .prev_i  (head_in),
        .data_o  (cell_data[k])
      );
    end else begin : g_body
      awr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring_shift),
        .prev_i  (cell_data[k-1]),
        .data_o  (cell_data[k])
      );
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    awr_axis u_axis (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (scan_ctrl),
      .now_i     (sample_q[a*AXIS_W +: AXIS_W]),
      .entry_i   (tail[a*AXIS_W +: AXIS_W]),
      .thr_i     (thr_q),
      .heading_o (heading[a]),
      .rank_o    (rank[a]),
      .spread_o  (spread[a])
    );
  end

  assign result = {
    {(OUT_DATA_W - AXES * (HEAD_W + RANK_W + SPREAD_W)){1'b0}},
    spread[2], spread[1], spread[0],
    rank[2], rank[1], rank[0],
    heading[2], heading[1], heading[0]
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= result;
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN && cnt_q == '0))
    else $error("Accepted word did not start a window scan.");

  a_scan_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cnt_q != CNT_LAST) |=>
      (state_q == ST_SCAN && cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("Window scan ended early or skipped a cell.");

  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("Finished item did not produce a result word.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("Result register overwritten while still pending.");

endmodule

FILE: test/accel_window_rank_heading_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_window_rank_heading_core_tb
// Self-checking bench for the window rank, spread and heading core.
// ----------------------------------------------------------------------------
// Sample words are queued by the stimulus process and fed to the slave stream
// by a clocked driver that inserts random gaps. Every accepted word runs
// through a bench-side copy of the 32-entry window, which predicts the heading,
// rank and spread of each axis. A clocked monitor takes result words under
// random back-pressure and checks every field against the oldest prediction.
// The damping threshold is changed between phases while the core is idle,
// including both extremes, and the samples mix full-range values, extremes and
// narrow clusters so that spreads land near the threshold.
// ----------------------------------------------------------------------------
module accel_window_rank_heading_core_tb;
  import awr_pkg::*;

  typedef struct packed {
    logic [3:0]          pad;
    logic [SPREAD_W-1:0] spread_z;
    logic [SPREAD_W-1:0] spread_y;
    logic [SPREAD_W-1:0] spread_x;
    logic [RANK_W-1:0]   rank_z;
    logic [RANK_W-1:0]   rank_y;
    logic [RANK_W-1:0]   rank_x;
    logic [HEAD_W-1:0]   heading_z;
    logic [HEAD_W-1:0]   heading_y;
    logic [HEAD_W-1:0]   heading_x;
  } heading_word_t;

  typedef enum int {
    MIX_FULL,
    MIX_CLUSTER,
    MIX_EXTREME
  } sample_mix_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // Fields from bit 0: sample_x, sample_y, sample_z, unused pad.
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // Fields from bit 0: heading_x, heading_y, heading_z, rank_x, rank_y,
  // rank_z, spread_x, spread_y, spread_z, zero pad.
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [THR_W-1:0]      cfg_data_i = '0;

  logic [IN_DATA_W-1:0]  sample_q[$];
  heading_word_t         pending_results[$];

  logic signed [AXIS_W-1:0] sample_history[WINDOW_DEPTH][AXES];
  int                       newest_slot = 0;
  logic [THR_W-1:0]         damp_thr = '0;

  bit quiet_mode = 1'b0;
  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int thr_writes = 0;

  accel_window_rank_heading_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      for (int a = 0; a < AXES; a++) begin
        sample_history[i][a] = '0;
      end
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic predict_result(input logic [IN_DATA_W-1:0] word);
    logic signed [AXIS_W-1:0] now[AXES];
    logic signed [AXIS_W-1:0] lo[AXES];
    logic signed [AXIS_W-1:0] hi[AXES];
    int                       count[AXES];
    int                       rank[AXES];
    int                       spread[AXES];
    logic [HEAD_W-1:0]        head[AXES];
    heading_word_t            r;
    int                       slot;
    for (int a = 0; a < AXES; a++) begin
      now[a] = word[a*AXIS_W +: AXIS_W];
      lo[a] = sample_history[0][a];
      hi[a] = sample_history[0][a];
      count[a] = 0;
    end
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      for (int a = 0; a < AXES; a++) begin
        if (sample_history[i][a] < lo[a]) lo[a] = sample_history[i][a];
        if (sample_history[i][a] > hi[a]) hi[a] = sample_history[i][a];
        if (now[a] >= sample_history[i][a]) count[a]++;
      end
    end
    slot = (newest_slot + 1) % WINDOW_DEPTH;
    for (int a = 0; a < AXES; a++) begin
      sample_history[slot][a] = now[a];
    end
    newest_slot = slot;
    for (int a = 0; a < AXES; a++) begin
      rank[a] = (100 * count[a]) / WINDOW_DEPTH;
      spread[a] = int'(hi[a]) - int'(lo[a]);
      if (spread[a] <= int'(damp_thr)) begin
        head[a] = HEAD_HOLD;
      end else if (rank[a] <= int'(RANK_Q1)) begin
        head[a] = HEAD_DOWN_FAST;
      end else if (rank[a] <= int'(RANK_Q2)) begin
        head[a] = HEAD_DOWN_SLOW;
      end else if (rank[a] <= int'(RANK_Q3)) begin
        head[a] = HEAD_UP_SLOW;
      end else begin
        head[a] = HEAD_UP_FAST;
      end
    end
    r = '0;
    r.heading_x = head[0];
    r.heading_y = head[1];
    r.heading_z = head[2];
    r.rank_x = RANK_W'(rank[0]);
    r.rank_y = RANK_W'(rank[1]);
    r.rank_z = RANK_W'(rank[2]);
    r.spread_x = SPREAD_W'(spread[0]);
    r.spread_y = SPREAD_W'(spread[1]);
    r.spread_z = SPREAD_W'(spread[2]);
    pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                words_out, name, got, want));
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] word);
    heading_word_t got;
    heading_word_t want;
    got = word;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result word %h", word));
    end else begin
      want = pending_results.pop_front();
      check_field("heading_x", got.heading_x, want.heading_x);
      check_field("heading_y", got.heading_y, want.heading_y);
      check_field("heading_z", got.heading_z, want.heading_z);
      check_field("rank_x", got.rank_x, want.rank_x);
      check_field("rank_y", got.rank_y, want.rank_y);
      check_field("rank_z", got.rank_z, want.rank_z);
      check_field("spread_x", got.spread_x, want.spread_x);
      check_field("spread_y", got.spread_y, want.spread_y);
      check_field("spread_z", got.spread_z, want.spread_z);
      check_field("pad", got.pad, want.pad);
    end
    words_out++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (sample_q.size() != 0 && (quiet_mode || $urandom_range(0, 99) >= 36)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sample_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        damp_thr = cfg_data_i;
        thr_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_result(s_axis_tdata);
        words_in++;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_mode || ($urandom_range(0, 99) >= 36);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_sample(input int x, input int y,
                                                       input int z);
    logic [AXIS_W-1:0] xb;
    logic [AXIS_W-1:0] yb;
    logic [AXIS_W-1:0] zb;
    xb = x[AXIS_W-1:0];
    yb = y[AXIS_W-1:0];
    zb = z[AXIS_W-1:0];
    return {2'b00, zb, yb, xb};
  endfunction

  function automatic int draw_axis(input sample_mix_e mix, input int center,
                                   input int width);
    int v;
    case (mix)
      MIX_CLUSTER: begin
        v = center + int'($urandom_range(0, 2 * width)) - width;
        if (v > 511) v = 511;
        if (v < -512) v = -512;
      end
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0: v = -512;
          1: v = 511;
          2: v = 0;
          default: v = center;
        endcase
      end
      default: begin
        v = int'($urandom_range(0, 1023)) - 512;
      end
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int n);
    int          center;
    int          width;
    int          pick;
    sample_mix_e mix;
    logic [IN_DATA_W-1:0] word;
    center = 0;
    width = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        center = int'($urandom_range(0, 1023)) - 512;
        width = $urandom_range(0, 40);
      end
      pick = $urandom_range(0, 99);
      mix = (pick < 50) ? MIX_CLUSTER : (pick < 80) ? MIX_FULL : MIX_EXTREME;
      word = pack_sample(draw_axis(mix, center, width), draw_axis(mix, center, width),
                         draw_axis(mix, center, width));
      if ($urandom_range(0, 7) == 0) word[IN_DATA_W-1 -: 2] = 2'($urandom);
      sample_q.push_back(word);
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A fresh window of zeros, field extremes and alternating bit patterns.
    sample_q.push_back(pack_sample(0, 0, 0));
    sample_q.push_back(pack_sample(511, -512, 1));
    sample_q.push_back(pack_sample(-512, 511, -1));
    sample_q.push_back(pack_sample(1, -1, 0));
    sample_q.push_back(pack_sample(341, -342, 170));
    sample_q.push_back(pack_sample(-342, 341, -171));
    for (int i = 0; i < 12; i++) begin
      sample_q.push_back(pack_sample(-480 + 80 * i, 480 - 80 * i, (i % 2) ? -300 : 300));
    end
    // Bits above the sample fields must be ignored.
    sample_q.push_back(pack_sample(100, -100, 0) | 32'hC000_0000);
    sample_q.push_back(pack_sample(-1, -1, -1) | 32'hC000_0000);
    wait_drained();

    write_threshold(THR_W'(1023));
    run_random(150);

    quiet_mode = 1'b1;
    write_threshold(THR_W'(0));
    run_random(300);
    quiet_mode = 1'b0;

    for (int k = 0; k < 5; k++) begin
      case (k)
        0: write_threshold(THR_W'(1));
        1: write_threshold(THR_W'(512));
        default: write_threshold(THR_W'($urandom_range(0, 60)));
      endcase
      run_random(216);
    end

    repeat (WINDOW_DEPTH + 16) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    $display("Sent %0d sample words and checked %0d result words across %0d threshold",
             words_in, words_out, thr_writes);
    $display("settings with random gaps and back-pressure; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("PASS accel_window_rank_heading_core");
    end else begin
      $display("FAIL accel_window_rank_heading_core");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("FAIL accel_window_rank_heading_core");
    $finish;
  end

endmodule
